// File: hw/rtl/pvc_pkg.sv
// Shared types, constants and pipeline stage map for the panel current model.
package pvc_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_EREF = 2'd0;
    localparam logic [1:0] CFG_TREF = 2'd1;
    localparam logic [1:0] CFG_IREF = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [10:0]        EREF_RST = 11'd1000;
    localparam logic signed [11:0] TREF_RST = 12'sd400;
    localparam logic [16:0]        IREF_RST = 17'd32768;

    // Model constants in their fixed-point units.
    localparam logic [35:0] XNUM     = 36'd45579337480;
    localparam logic [13:0] KELVIN16 = 14'd4370;
    localparam logic [20:0] I0_Q     = 21'd1072213;
    localparam logic [30:0] MU_Q     = 31'd1755216382;
    localparam logic [37:0] ISH_Q    = 38'd156562264865;
    localparam logic signed [17:0] OUT_MAX = 18'sd131071;
    localparam logic signed [17:0] OUT_MIN = -18'sd131072;

    // Floor of 2^32 / n for the Taylor term divisors n = 2 .. 10.
    localparam logic [31:0] RECIP [9] = '{
        32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882, 32'd613566756, 32'd536870912, 32'd477218588,
        32'd429496729
    };

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Pipeline stage map of the back part.
    localparam int XQ_BITS  = 25;
    localparam int N_TERMS  = 9;
    localparam int TAY_BASE = XQ_BITS;
    localparam int ST_ID    = TAY_BASE + 3 * N_TERMS + 1;
    localparam int ST_MUL   = ST_ID + 1;
    localparam int ST_SUB   = ST_MUL + 1;
    localparam int ST_DVD   = ST_SUB + 1;
    localparam int FQ_BITS  = 30;
    localparam int ST_OUT   = ST_DVD + FQ_BITS + 1;
    localparam int NST      = ST_OUT + 1;

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic [10:0]        e;
        logic [12:0]        tabs;
        logic signed [12:0] dt;
        logic [10:0]        eref;
    } item_t;

endpackage

// File: hw/rtl/pvc_front.sv
// Front part: configuration registers and classification of incoming items.
module pvc_front
    import pvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [10:0]        irradiance,
    input  logic signed [11:0] temperature,
    input  logic               q_full,
    output logic               push,
    output item_t              item,
    output logic [16:0]        ref_current
);

    logic [10:0]        eref_reg;
    logic signed [11:0] tref_reg;
    logic [16:0]        iref_reg;
    logic signed [13:0] tk;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eref_reg <= EREF_RST;
            tref_reg <= TREF_RST;
            iref_reg <= IREF_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EREF: eref_reg <= cfg_data[10:0];
                CFG_TREF: tref_reg <= $signed(cfg_data[11:0]);
                CFG_IREF: iref_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign ref_current = iref_reg;

    // A transaction is taken whenever the queue has room.
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Classification: absolute temperature, temperature offset, guarded reference.
    assign tk        = 14'(temperature) + $signed(KELVIN16);
    assign item.e    = irradiance;
    assign item.tabs = tk[12:0];
    assign item.dt   = 13'(temperature) - 13'(tref_reg);
    assign item.eref = (eref_reg == 11'd0) ? 11'd1 : eref_reg;

endmodule

// File: hw/rtl/pvc_queue.sv
// Short queue of classified items between the front and the back part.
module pvc_queue
    import pvc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head
);

    item_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] rd_reg;
    logic [QAW:0]   count_reg;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/pvc_back.sv
// Back part: pipelined exponent division, Taylor series, current sum and final division.
module pvc_back
    import pvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               pop,
    input  logic [16:0]        ref_current,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] panel_current,
    output logic               saturated
);

    logic  vld_reg  [NST];
    item_t item_reg [NST];
    logic  en;

    // The whole line advances unless the output transaction is held.
    assign en  = !vld_reg[NST-1] || !out_stall;
    assign pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= q_item;
            for (int i = 1; i < NST; i++)
            begin
                item_reg[i] <= item_reg[i-1];
            end
        end
    end

    // Exponent x = XNUM / tabs in Q24, one quotient bit per stage.
    logic [12:0]        xr_reg [XQ_BITS+1];
    logic [XQ_BITS-1:0] xq_reg [XQ_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xr_reg[0] <= 13'(XNUM[35:XQ_BITS]);
            xq_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= XQ_BITS; k++)
    begin : g_xdiv
        logic [13:0] trial;
        logic [13:0] dsr;
        assign trial = {xr_reg[k-1], XNUM[XQ_BITS-k]};
        assign dsr   = {1'b0, item_reg[k-1].tabs};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= dsr)
                begin
                    xr_reg[k] <= 13'(trial - dsr);
                    xq_reg[k] <= {xq_reg[k-1][XQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    xr_reg[k] <= trial[12:0];
                    xq_reg[k] <= {xq_reg[k-1][XQ_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Taylor terms n = 2 .. 10: multiply by x, then divide by n via reciprocal.
    logic [49:0] pr_reg [N_TERMS];
    logic [24:0] xa_reg [N_TERMS];
    logic [26:0] sa_reg [N_TERMS];
    logic [57:0] m_reg  [N_TERMS];
    logic [25:0] v_reg  [N_TERMS];
    logic [24:0] xb_reg [N_TERMS];
    logic [26:0] sb_reg [N_TERMS];
    logic [24:0] tm_reg [N_TERMS];
    logic [24:0] xc_reg [N_TERMS];
    logic [26:0] sc_reg [N_TERMS];

    for (genvar j = 0; j < N_TERMS; j++)
    begin : g_term
        localparam logic [3:0] N = 4'(j + 2);
        logic [24:0] t_in;
        logic [24:0] x_in;
        logic [26:0] s_in;
        logic [25:0] qe;
        logic [29:0] qn;

        if (j == 0)
        begin : g_first
            assign t_in = xq_reg[XQ_BITS];
            assign x_in = xq_reg[XQ_BITS];
            assign s_in = 27'(xq_reg[XQ_BITS]);
        end
        else
        begin : g_next
            assign t_in = tm_reg[j-1];
            assign x_in = xc_reg[j-1];
            assign s_in = sc_reg[j-1];
        end

        assign qe = m_reg[j][57:32];
        assign qn = 30'(qe) * 30'(N);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pr_reg[j] <= 50'(t_in) * 50'(x_in);
                xa_reg[j] <= x_in;
                sa_reg[j] <= s_in;

                v_reg[j]  <= pr_reg[j][49:24];
                m_reg[j]  <= 58'(pr_reg[j][49:24]) * 58'(RECIP[j]);
                xb_reg[j] <= xa_reg[j];
                sb_reg[j] <= sa_reg[j];

                // The reciprocal estimate is at most one below the quotient.
                if ((30'(v_reg[j]) - qn) >= 30'(N))
                begin
                    tm_reg[j] <= 25'(qe + 1'b1);
                    sc_reg[j] <= sb_reg[j] + 27'(qe + 1'b1);
                end
                else
                begin
                    tm_reg[j] <= 25'(qe);
                    sc_reg[j] <= sb_reg[j] + 27'(qe);
                end
                xc_reg[j] <= xb_reg[j];
            end
        end
    end

    // Diode current and temperature-corrected reference current.
    logic [48:0]        idp;
    logic signed [44:0] mud;
    logic [16:0]        id_reg;
    logic signed [51:0] s_reg;

    assign idp = 49'(sc_reg[N_TERMS-1]) * 49'(I0_Q) + 49'(64'h8000_0000);
    assign mud = $signed({1'b0, MU_Q}) * item_reg[ST_ID-1].dt;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_reg <= idp[48:32];
            s_reg  <= $signed({3'b000, ref_current, 32'h0}) + 52'(mud);
        end
    end

    // Scaled photocurrent and scaled losses.
    logic signed [62:0] p1_reg;
    logic [48:0]        p2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= $signed({1'b0, item_reg[ST_MUL-1].e}) * s_reg;
            p2_reg <= 49'(item_reg[ST_MUL-1].eref) * (49'(id_reg) + 49'(ISH_Q));
        end
    end

    // Sign and magnitude of the numerator.
    logic signed [62:0] num;
    logic [61:0]        mag_reg;
    logic               neg_reg;

    assign num = p1_reg - $signed({14'b0, p2_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= num[62];
            mag_reg <= num[62] ? 62'(-num) : 62'(num);
        end
    end

    // Rounding bias, then drop the 2^32 scale before dividing by eref.
    logic [62:0]        rnd;
    logic [10:0]        fr_reg [FQ_BITS+1];
    logic [FQ_BITS-1:0] fq_reg [FQ_BITS+1];
    logic [FQ_BITS-1:0] fd_reg [FQ_BITS+1];
    logic               fn_reg [FQ_BITS+1];

    assign rnd = 63'(mag_reg) + (63'(item_reg[ST_DVD-1].eref) << 31);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg[0] <= '0;
            fq_reg[0] <= '0;
            fd_reg[0] <= rnd[61:32];
            fn_reg[0] <= neg_reg;
        end
    end

    for (genvar k = 1; k <= FQ_BITS; k++)
    begin : g_fdiv
        logic [11:0] trial;
        logic [11:0] dsr;
        assign trial = {fr_reg[k-1], fd_reg[k-1][FQ_BITS-k]};
        assign dsr   = {1'b0, item_reg[ST_DVD+k-1].eref};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fd_reg[k] <= fd_reg[k-1];
                fn_reg[k] <= fn_reg[k-1];
                if (trial >= dsr)
                begin
                    fr_reg[k] <= 11'(trial - dsr);
                    fq_reg[k] <= {fq_reg[k-1][FQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    fr_reg[k] <= trial[10:0];
                    fq_reg[k] <= {fq_reg[k-1][FQ_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Saturation into the output register.
    logic [FQ_BITS-1:0] qf;
    logic signed [17:0] pc_reg;
    logic               sat_reg;

    assign qf = fq_reg[FQ_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fn_reg[FQ_BITS])
            begin
                if (qf > FQ_BITS'(131072))
                begin
                    pc_reg  <= OUT_MIN;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    pc_reg  <= 18'(-$signed({1'b0, qf}));
                    sat_reg <= 1'b0;
                end
            end
            else
            begin
                if (qf > FQ_BITS'(131071))
                begin
                    pc_reg  <= OUT_MAX;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    pc_reg  <= $signed(qf[17:0]);
                    sat_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid     = vld_reg[NST-1];
    assign panel_current = pc_reg;
    assign saturated     = sat_reg;

endmodule

// File: hw/rtl/pv_panel_current_model_top.sv
// Top level of the panel current model: front, queue and back part.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   irradiance, temperature
//  out       source     out_valid / out_stall panel_current, saturated
//  cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction is accepted per cycle while the queue has room; each result passes the
// 25-stage exponent divider, 27 Taylor stages and 30-stage final divider in turn.
// Reset clears all valid bits and queue pointers and loads the configuration registers
// with their reset values, all at once.
// A held output freezes the whole back pipeline; the four-entry queue keeps taking
// input until it is full, and then in_stall rises.
module pv_panel_current_model_top
    import pvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [10:0]        irradiance,
    input  logic signed [11:0] temperature,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] panel_current,
    output logic               saturated
);

    item_t       f_item;
    item_t       q_item;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_valid;
    logic [16:0] ref_current;

    pvc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .irradiance  (irradiance),
        .temperature (temperature),
        .q_full      (q_full),
        .push        (push),
        .item        (f_item),
        .ref_current (ref_current)
    );

    pvc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (f_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_item)
    );

    pvc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .ref_current   (ref_current),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .panel_current (panel_current),
        .saturated     (saturated)
    );

endmodule

// File: hw/rtl/pvc_checker.sv
// Port-level checks of the panel current model and their binding to the top level.
module pvc_checker
    import pvc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [1:0]         cfg_index,
    input logic [16:0]        cfg_data,
    input logic               in_valid,
    input logic               in_stall,
    input logic [10:0]        irradiance,
    input logic signed [11:0] temperature,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [17:0] panel_current,
    input logic               saturated
);

    // A held result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // A held result does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(panel_current) && $stable(saturated))
        else $error("output payload changed while stalled");

    // A saturated result sits at one end of the range.
    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> panel_current == OUT_MAX || panel_current == OUT_MIN)
        else $error("saturated result is not clamped");

    // No result appears straight out of reset.
    a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result present right after reset");

    // With the output free the queue drains, so a full queue opens again.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_stall |=> !in_stall)
        else $error("input stall held while the back part was free");

endmodule

bind pv_panel_current_model_top pvc_checker u_pvc_checker (.*);

// File: test/pv_panel_current_model_top_tb.sv
// Self-checking testbench for the panel current model top level.
`timescale 1ns / 100ps

module pv_panel_current_model_top_tb;
    import pvc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;
    localparam int ITEMS_PER_PHASE = 200;

    typedef struct packed {
        logic signed [17:0] cur;
        logic               sat;
    } current_t;

    typedef struct {
        logic [10:0]        e;
        logic signed [11:0] t;
        logic [10:0]        eref;
        logic signed [11:0] tref;
        logic [16:0]        iref;
        bit                 typed;
        current_t           want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [10:0]        irradiance;
    logic signed [11:0] temperature;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] panel_current;
    logic               saturated;

    // Shadow copy of the configuration registers.
    logic [10:0]        sh_eref;
    logic signed [11:0] sh_tref;
    logic [16:0]        sh_iref;

    current_t currents_due[$];
    int       errors     = 0;
    int       n_sent     = 0;
    int       n_checked  = 0;
    int       n_sat      = 0;
    int       n_cfg      = 0;
    int       cycles     = 0;
    int       phase_no   = -1;
    int       idle_pct   = 0;
    int       stall_pct  = 0;
    bit       hold_off   = 1'b0;

    pv_panel_current_model_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .irradiance    (irradiance),
        .temperature   (temperature),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .panel_current (panel_current),
        .saturated     (saturated)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Expected panel current from the diode model with the shadow configuration.
    function automatic current_t predict_current(logic [10:0] e, logic signed [11:0] t);
        longint          eref;
        longint          s;
        longint          num;
        longint          id;
        longint unsigned tabs;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        current_t        res;
        eref = (sh_eref == 0) ? 1 : longint'(sh_eref);
        s = longint'(sh_iref) * 64'sh1_0000_0000
            + longint'(MU_Q) * (longint'(t) - longint'(sh_tref));
        tabs = longint'(t) + longint'(KELVIN16);
        x = longint'(XNUM) / tabs;
        term = x;
        sum = x;
        for (int n = 2; n <= 10; n++)
        begin
            term = ((term * x) >> 24) / n;
            sum += term;
        end
        id = longint'((sum * longint'(I0_Q) + 64'h8000_0000) >> 32);
        num = longint'(e) * s - eref * (id + longint'(ISH_Q));
        den = longint'(eref) << 32;
        mag = (num < 0) ? -num : num;
        q = (mag + (den >> 1)) / den;
        res.sat = 1'b0;
        if (num < 0)
        begin
            if (q > 131072)
            begin
                res.cur = OUT_MIN;
                res.sat = 1'b1;
            end
            else
                res.cur = 18'(-q);
        end
        else
        begin
            if (q > 131071)
            begin
                res.cur = OUT_MAX;
                res.sat = 1'b1;
            end
            else
                res.cur = 18'(q);
        end
        return res;
    endfunction

    // Offer one sample, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_sample(input logic [10:0] e, input logic signed [11:0] t,
                               input current_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        irradiance  <= e;
        temperature <= t;
        do
            @(posedge clk);
        while (in_stall);
        currents_due.push_back(want);
        n_sent++;
    endtask

    // Let every pending result come out before touching the registers.
    task automatic drain();
        in_valid <= 1'b0;
        wait (currents_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // One register write transaction; the shadow follows with the low bits of the data.
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_EREF: sh_eref = d[10:0];
            CFG_TREF: sh_tref = d[11:0];
            CFG_IREF: sh_iref = d;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [16:0] e, input logic [16:0] t,
                             input logic [16:0] i);
        write_reg(CFG_EREF, e);
        write_reg(CFG_TREF, t);
        write_reg(CFG_IREF, i);
    endtask

    // Receiver side: random stall plus the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Long output hold-off early in the first random phase so the input backs up.
    initial
    begin
        wait (phase_no == 0 && n_sent >= 30);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            current_t exp_res;
            if (currents_due.size() == 0)
            begin
                $display("%0t: unexpected result current=%0d sat=%0b",
                         $time, panel_current, saturated);
                errors++;
            end
            else
            begin
                exp_res = currents_due.pop_front();
                n_checked++;
                if (saturated)
                    n_sat++;
                if (panel_current !== exp_res.cur)
                begin
                    $display("%0t: panel_current expected %0d actual %0d",
                             $time, exp_res.cur, panel_current);
                    errors++;
                end
                if (saturated !== exp_res.sat)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, exp_res.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, currents_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed rows: typed expectations only where obvious.
    stim_row_t rows[$];

    function automatic void add_row(logic [10:0] e, logic signed [11:0] t,
                                    logic [10:0] eref, logic signed [11:0] tref,
                                    logic [16:0] iref, bit typed,
                                    logic signed [17:0] cur, logic sat);
        stim_row_t r;
        r.e = e; r.t = t; r.eref = eref; r.tref = tref; r.iref = iref;
        r.typed = typed;
        r.want.cur = cur;
        r.want.sat = sat;
        rows.push_back(r);
    endfunction

    // Main sequence.
    initial
    begin
        logic [10:0]        e;
        logic signed [11:0] t;
        current_t           want;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_EREF;
        cfg_data    = '0;
        in_valid    = 1'b0;
        irradiance  = '0;
        temperature = '0;
        sh_eref     = EREF_RST;
        sh_tref     = TREF_RST;
        sh_iref     = IREF_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration, then zero reference irradiance, then both saturation ends, then the largest references.
        add_row(0, 400, 1000, 400, 32768, 1, -18'sd36, 0);
        add_row(2047, 2000, 1000, 400, 32768, 0, 0, 0);
        add_row(1000, 400, 1000, 400, 32768, 0, 0, 0);
        add_row(0, -12'sd2048, 1000, 400, 32768, 0, 0, 0);
        add_row(2047, -12'sd2048, 1000, 400, 32768, 0, 0, 0);
        add_row(1, -12'sd640, 1000, 400, 32768, 0, 0, 0);
        add_row(2047, 12'sd2047, 1000, 400, 32768, 0, 0, 0);
        add_row(1024, 0, 1000, 400, 32768, 0, 0, 0);
        add_row(1, 400, 0, 400, 32768, 0, 0, 0);
        add_row(2047, 2000, 0, 400, 32768, 1, OUT_MAX, 1);
        add_row(0, 0, 0, 400, 32768, 0, 0, 0);
        add_row(2047, -12'sd2048, 1, 2000, 0, 1, OUT_MIN, 1);
        add_row(0, 0, 1, 2000, 0, 0, 0, 0);
        add_row(1, 2000, 1, 2000, 0, 0, 0, 0);
        add_row(2047, 2000, 2047, -12'sd640, 131071, 0, 0, 0);
        add_row(2047, -12'sd2048, 2047, -12'sd640, 131071, 0, 0, 0);
        add_row(0, 2000, 2047, -12'sd640, 131071, 0, 0, 0);
        add_row(1, 0, 2047, -12'sd640, 131071, 0, 0, 0);
        add_row(1365, 12'sd1365, 2047, -12'sd640, 131071, 0, 0, 0);

        foreach (rows[k])
        begin
            if (rows[k].eref !== sh_eref || rows[k].tref !== sh_tref
                || rows[k].iref !== sh_iref)
            begin
                drain();
                write_all(17'(rows[k].eref), 17'(rows[k].tref), rows[k].iref);
            end
            want = rows[k].typed ? rows[k].want : predict_current(rows[k].e, rows[k].t);
            send_sample(rows[k].e, rows[k].t, want);
        end

        // Random phases under different idling patterns and configurations.
        for (int p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                0: write_all(17'(EREF_RST), 17'(TREF_RST), 17'(IREF_RST));
                1: write_all(17'($urandom_range(1, 2047)), 17'($urandom_range(0, 17'h1FFFF)),
                             17'($urandom_range(0, 17'h1FFFF)));
                2: write_all(17'h1F800 | 17'($urandom_range(0, 1)),
                             17'h1F000 | 17'($urandom_range(0, 4095)),
                             17'($urandom_range(0, 17'h1FFFF)));
                default: write_all(17'($urandom_range(1, 2047)),
                                   17'($urandom_range(0, 2640)) - 17'd640,
                                   17'h1FFFF);
            endcase
            idle_pct  = (p == 1) ? 84 : (p == 3) ? 16 : 0;
            stall_pct = (p == 2) ? 84 : (p == 3) ? 16 : 0;
            phase_no  = p;
            repeat (ITEMS_PER_PHASE)
            begin
                case ($urandom_range(9))
                    0: e = $urandom_range(0, 1) ? 11'd2047 : 11'd0;
                    1: e = 11'($urandom_range(0, 15));
                    default: e = 11'($urandom_range(0, 2047));
                endcase
                if ($urandom_range(3) == 0)
                    t = 12'($urandom_range(0, 4095));
                else
                    t = 12'($urandom_range(0, 2640)) - 12'sd640;
                send_sample(e, t, predict_current(e, t));
            end
        end

        drain();
        $display("Sent %0d samples over directed rows and four idling phases; %0d results",
                 n_sent, n_checked);
        $display("checked, %0d of them saturated, %0d register writes.", n_sat, n_cfg);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pvc_pkg.sv
hw/rtl/pvc_front.sv
hw/rtl/pvc_queue.sv
hw/rtl/pvc_back.sv
hw/rtl/pv_panel_current_model_top.sv
hw/rtl/pvc_checker.sv
test/pv_panel_current_model_top_tb.sv
